### hw/rtl/gzhp_pkg.sv
// types and constants shared by the gzip header parser and its checker
package gzhp_pkg;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic        finished;
      logic [3:0]  error_code;
      logic [29:0] body_offset;
      logic        in_header;
   } rsp_type;

   typedef enum logic [9:0] {
      PH_FIXED   = 10'b00_0000_0001,
      PH_XLEN_LO = 10'b00_0000_0010,
      PH_XLEN_HI = 10'b00_0000_0100,
      PH_EXTRA   = 10'b00_0000_1000,
      PH_NAME    = 10'b00_0001_0000,
      PH_COMMENT = 10'b00_0010_0000,
      PH_CRC0    = 10'b00_0100_0000,
      PH_CRC1    = 10'b00_1000_0000,
      PH_BODY    = 10'b01_0000_0000,
      PH_DEAD    = 10'b10_0000_0000
   } phase_type;

   localparam logic [3:0] ERR_NONE        = 4'd0;
   localparam logic [3:0] ERR_HEADER      = 4'd1;
   localparam logic [3:0] ERR_FLAGS       = 4'd2;
   localparam logic [3:0] ERR_XLEN        = 4'd3;
   localparam logic [3:0] ERR_EXTRA       = 4'd4;
   localparam logic [3:0] ERR_NAME        = 4'd5;
   localparam logic [3:0] ERR_COMMENT     = 4'd6;
   localparam logic [3:0] ERR_CRC         = 4'd7;
   localparam logic [3:0] ERR_TRUNCATED   = 4'd8;

   localparam logic [7:0] ID1_BYTE        = 8'h1f;
   localparam logic [7:0] ID2_BYTE        = 8'h8b;
   localparam logic [7:0] CM_DEFLATE      = 8'h08;
   localparam logic [7:0] FLG_RESERVED    = 8'he0;
   localparam logic [7:0] FLG_FEXTRA      = 8'h04;
   localparam logic [7:0] FLG_FNAME       = 8'h08;
   localparam logic [7:0] FLG_FCOMMENT    = 8'h10;
   localparam logic [7:0] FLG_FHCRC       = 8'h02;

   localparam int MIN_FILE_BYTES  = 18;
   localparam int TRAILER_BYTES   = 8;
   localparam int FIXED_LAST_POS  = 9;

endpackage

### hw/rtl/gzip_header_parser_core.sv
// gzip member header parser: one byte per beat, verdict on the last byte
//
// req channel: one byte of the gzip file per beat, end_of_file marks the last.
// rsp channel: one result beat for every request beat, in order. in_header
// tells whether that byte belongs to the member header. On the last byte
// finished is 1 and error_code gives the first error in file order, or zero
// with body_offset pointing at the first deflate byte.
// The result beat shows in the cycle after its request beat. Throughput is
// one byte per cycle while the receiver does not stall: the header state
// is updated in the same cycle a byte is taken and the result lands in a
// single output register. When the receiver stalls, the result register
// holds its beat and req_stall is raised only while that register is full
// and stalled, so a new byte is taken in the same cycle the held beat leaves.
// Synchronous reset empties the result register and returns the walker to
// the start of a file; the walker also returns there after every last byte.
// Byte and header counters saturate at 2^COUNT_BITS - 1.
module gzip_header_parser_core #(
   parameter int COUNT_BITS = 30
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gzhp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gzhp_pkg::rsp_type rsp_data
);
   import gzhp_pkg::*;

   localparam logic [2:0] STAGE_XLEN    = 3'd0;
   localparam logic [2:0] STAGE_NAME    = 3'd1;
   localparam logic [2:0] STAGE_COMMENT = 3'd2;
   localparam logic [2:0] STAGE_CRC     = 3'd3;
   localparam logic [2:0] STAGE_BODY    = 3'd4;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   function automatic phase_type enter_section(logic [2:0] stage, logic [7:0] flags);
      phase_type ph;
      if (stage <= STAGE_XLEN && (flags & FLG_FEXTRA) != 8'h00) begin
         ph = PH_XLEN_LO;
      end else if (stage <= STAGE_NAME && (flags & FLG_FNAME) != 8'h00) begin
         ph = PH_NAME;
      end else if (stage <= STAGE_COMMENT && (flags & FLG_FCOMMENT) != 8'h00) begin
         ph = PH_COMMENT;
      end else if (stage <= STAGE_CRC && (flags & FLG_FHCRC) != 8'h00) begin
         ph = PH_CRC0;
      end else begin
         ph = PH_BODY;
      end
      return ph;
   endfunction

   phase_type             phase_ff, phase_in, phase_next;
   logic [COUNT_BITS-1:0] byte_count_ff, byte_count_in, byte_count_inc;
   logic [COUNT_BITS-1:0] header_length_ff, header_length_in, header_length_next;
   logic [7:0]            flag_bits_ff, flag_bits_in, flag_bits_next;
   logic [15:0]           skip_remaining_ff, skip_remaining_in, skip_remaining_next;
   logic [7:0]            extra_len_low_ff, extra_len_low_in, extra_len_low_next;
   logic [3:0]            first_error_ff, first_error_in, first_error_next;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic [COUNT_BITS-1:0] pos;
   logic [7:0]            b;
   logic [3:0]            err;
   logic [3:0]            code;
   logic [15:0]           xlen;
   logic [COUNT_BITS:0]   n_wide, limit_wide;
   logic [32:0]           hl_wide;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign pos            = byte_count_ff;
   assign b              = req_data.byte_in;
   assign byte_count_inc = (pos == COUNT_MAX) ? pos : pos + COUNT_BITS'(1);
   assign xlen           = {b, extra_len_low_ff};

   always_comb begin
      phase_next          = phase_ff;
      flag_bits_next      = flag_bits_ff;
      skip_remaining_next = skip_remaining_ff;
      extra_len_low_next  = extra_len_low_ff;
      first_error_next    = first_error_ff;
      err                 = ERR_NONE;
      case (phase_ff)
         PH_FIXED: begin
            if ((pos == COUNT_BITS'(0) && b != ID1_BYTE) ||
                (pos == COUNT_BITS'(1) && b != ID2_BYTE) ||
                (pos == COUNT_BITS'(2) && b != CM_DEFLATE)) begin
               err = ERR_HEADER;
            end else if (pos == COUNT_BITS'(3)) begin
               flag_bits_next = b;
               if ((b & FLG_RESERVED) != 8'h00) begin
                  err = ERR_FLAGS;
               end
            end
            if (err != ERR_NONE) begin
               first_error_next = err;
               phase_next       = PH_DEAD;
            end else if (pos >= COUNT_BITS'(FIXED_LAST_POS)) begin
               phase_next = enter_section(STAGE_XLEN, flag_bits_ff);
            end
         end
         PH_XLEN_LO: begin
            extra_len_low_next = b;
            phase_next         = PH_XLEN_HI;
         end
         PH_XLEN_HI: begin
            if (xlen == 16'd0) begin
               phase_next = enter_section(STAGE_NAME, flag_bits_ff);
            end else begin
               skip_remaining_next = xlen;
               phase_next          = PH_EXTRA;
            end
         end
         PH_EXTRA: begin
            if (skip_remaining_ff <= 16'd1) begin
               skip_remaining_next = 16'd0;
               phase_next          = enter_section(STAGE_NAME, flag_bits_ff);
            end else begin
               skip_remaining_next = skip_remaining_ff - 16'd1;
            end
         end
         PH_NAME: begin
            if (b == 8'h00) begin
               phase_next = enter_section(STAGE_COMMENT, flag_bits_ff);
            end
         end
         PH_COMMENT: begin
            if (b == 8'h00) begin
               phase_next = enter_section(STAGE_CRC, flag_bits_ff);
            end
         end
         PH_CRC0: begin
            phase_next = PH_CRC1;
         end
         PH_CRC1: begin
            phase_next = enter_section(STAGE_BODY, flag_bits_ff);
         end
         default: begin
         end
      endcase
   end

   assign header_length_next = (phase_next == PH_BODY && phase_ff != PH_BODY) ?
                               byte_count_inc : header_length_ff;

   assign n_wide     = {1'b0, pos} + (COUNT_BITS + 1)'(1);
   assign limit_wide = {1'b0, header_length_next} + (COUNT_BITS + 1)'(TRAILER_BYTES);
   assign hl_wide    = {{(33 - COUNT_BITS){1'b0}}, header_length_next};

   always_comb begin
      if (pos < COUNT_BITS'(MIN_FILE_BYTES - 1)) begin
         code = ERR_HEADER;
      end else if (first_error_next != ERR_NONE) begin
         code = first_error_next;
      end else begin
         case (phase_next)
            PH_XLEN_LO: code = ERR_XLEN;
            PH_XLEN_HI: code = ERR_XLEN;
            PH_EXTRA:   code = ERR_EXTRA;
            PH_NAME:    code = ERR_NAME;
            PH_COMMENT: code = ERR_COMMENT;
            PH_CRC0:    code = ERR_CRC;
            PH_CRC1:    code = ERR_CRC;
            PH_BODY:    code = (n_wide < limit_wide) ? ERR_TRUNCATED : ERR_NONE;
            default:    code = ERR_HEADER;
         endcase
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      byte_count_in     = byte_count_ff;
      header_length_in  = header_length_ff;
      flag_bits_in      = flag_bits_ff;
      skip_remaining_in = skip_remaining_ff;
      extra_len_low_in  = extra_len_low_ff;
      first_error_in    = first_error_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_data_in       = rsp_data_ff;
      if (accept) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.in_header = (phase_ff != PH_BODY && phase_ff != PH_DEAD);
         if (req_data.end_of_file) begin
            rsp_data_in.finished    = 1'b1;
            rsp_data_in.error_code  = code;
            rsp_data_in.body_offset = (code == ERR_NONE) ? hl_wide[29:0] : 30'd0;
            phase_in          = PH_FIXED;
            byte_count_in     = '0;
            header_length_in  = '0;
            flag_bits_in      = 8'h00;
            skip_remaining_in = 16'd0;
            extra_len_low_in  = 8'h00;
            first_error_in    = ERR_NONE;
         end else begin
            rsp_data_in.finished    = 1'b0;
            rsp_data_in.error_code  = ERR_NONE;
            rsp_data_in.body_offset = 30'd0;
            phase_in          = phase_next;
            byte_count_in     = byte_count_inc;
            header_length_in  = header_length_next;
            flag_bits_in      = flag_bits_next;
            skip_remaining_in = skip_remaining_next;
            extra_len_low_in  = extra_len_low_next;
            first_error_in    = first_error_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_FIXED;
         byte_count_ff     <= '0;
         header_length_ff  <= '0;
         flag_bits_ff      <= 8'h00;
         skip_remaining_ff <= 16'd0;
         extra_len_low_ff  <= 8'h00;
         first_error_ff    <= ERR_NONE;
         rsp_valid_ff      <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         byte_count_ff     <= byte_count_in;
         header_length_ff  <= header_length_in;
         flag_bits_ff      <= flag_bits_in;
         skip_remaining_ff <= skip_remaining_in;
         extra_len_low_ff  <= extra_len_low_in;
         first_error_ff    <= first_error_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### hw/rtl/gzhp_checker.sv
// port-level checks for the gzip header parser, bound to gzip_header_parser_core
module gzhp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input gzhp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input gzhp_pkg::rsp_type rsp_data
);
   import gzhp_pkg::*;

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while result register can move");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat changed");

   a_quiet_mid : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.finished) |->
      (rsp_data.error_code == ERR_NONE && rsp_data.body_offset == 30'd0))
      else $error("verdict fields set on a beat that is not the last");

   a_err_offset : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.finished && rsp_data.error_code != ERR_NONE) |->
      (rsp_data.body_offset == 30'd0))
      else $error("body offset reported with an error");

endmodule

bind gzip_header_parser_core gzhp_checker u_gzhp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### bench/gzip_header_parser_core_test.sv
// self-checking testbench for gzip_header_parser_core: directed and random gzip files
module gzip_header_parser_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import gzhp_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_BYTES = 150;
   localparam logic [29:0] COUNT_MAX = '1;

   typedef logic [7:0] octet_queue_type[$];

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   gzip_header_parser_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // header walker state of the predictor
   phase_type   walk_phase = PH_FIXED;
   logic [29:0] walk_count = '0;
   logic [29:0] walk_hdr_len = '0;
   logic [7:0]  walk_flags = '0;
   logic [7:0]  walk_xlen_lo = '0;
   logic [16:0] walk_skip = '0;
   logic [3:0]  walk_err = ERR_NONE;

   rsp_type due_results[$];
   rsp_type want_rsp;

   int  mismatches = 0;
   int  beats_checked = 0;
   int  bytes_sent = 0;
   int  files_sent = 0;
   int  cycles = 0;
   int  verdict_count[0:8];
   int  stall_run = 0;
   bit  tx_calm = 1'b0;
   bit  rx_calm = 1'b0;

   function automatic void walk_reset();
      walk_phase = PH_FIXED;
      walk_count = '0;
      walk_hdr_len = '0;
      walk_flags = '0;
      walk_xlen_lo = '0;
      walk_skip = '0;
      walk_err = ERR_NONE;
   endfunction

   // move to the first optional section at or after s that the flags ask for
   function automatic void walk_enter(phase_type s, logic [29:0] pos);
      if (s <= PH_XLEN_LO && (walk_flags & FLG_FEXTRA) != 0) begin
         walk_phase = PH_XLEN_LO;
      end else if (s <= PH_NAME && (walk_flags & FLG_FNAME) != 0) begin
         walk_phase = PH_NAME;
      end else if (s <= PH_COMMENT && (walk_flags & FLG_FCOMMENT) != 0) begin
         walk_phase = PH_COMMENT;
      end else if (s <= PH_CRC0 && (walk_flags & FLG_FHCRC) != 0) begin
         walk_phase = PH_CRC0;
      end else begin
         walk_hdr_len = (pos == COUNT_MAX) ? COUNT_MAX : pos + 30'd1;
         walk_phase = PH_BODY;
      end
   endfunction

   function automatic rsp_type walk_header_byte(req_type item);
      rsp_type     res;
      logic [29:0] pos;
      logic [30:0] n;
      logic [3:0]  e;
      logic [3:0]  code;
      logic [16:0] len;
      pos = walk_count;
      e = ERR_NONE;
      res = '0;
      res.in_header = (walk_phase < PH_BODY);
      case (walk_phase)
         PH_FIXED: begin
            if ((pos == 0 && item.byte_in != ID1_BYTE) || (pos == 1 && item.byte_in != ID2_BYTE)
                || (pos == 2 && item.byte_in != CM_DEFLATE)) begin
               e = ERR_HEADER;
            end else if (pos == 3) begin
               walk_flags = item.byte_in;
               if ((item.byte_in & FLG_RESERVED) != 0) e = ERR_FLAGS;
            end
            if (e != ERR_NONE) begin
               walk_err = e;
               walk_phase = PH_DEAD;
            end else if (pos >= FIXED_LAST_POS) begin
               walk_enter(PH_XLEN_LO, pos);
            end
         end
         PH_XLEN_LO: begin
            walk_xlen_lo = item.byte_in;
            walk_phase = PH_XLEN_HI;
         end
         PH_XLEN_HI: begin
            len = {1'b0, item.byte_in, walk_xlen_lo};
            if (len == 0) begin
               walk_enter(PH_NAME, pos);
            end else begin
               walk_skip = len;
               walk_phase = PH_EXTRA;
            end
         end
         PH_EXTRA: begin
            if (walk_skip > 0) walk_skip = walk_skip - 17'd1;
            if (walk_skip == 0) walk_enter(PH_NAME, pos);
         end
         PH_NAME: begin
            if (item.byte_in == 8'h00) walk_enter(PH_COMMENT, pos);
         end
         PH_COMMENT: begin
            if (item.byte_in == 8'h00) walk_enter(PH_CRC0, pos);
         end
         PH_CRC0: begin
            walk_phase = PH_CRC1;
         end
         PH_CRC1: begin
            walk_enter(PH_BODY, pos);
         end
         default: ;
      endcase
      if (walk_count != COUNT_MAX) walk_count = walk_count + 30'd1;
      if (item.end_of_file) begin
         n = {1'b0, pos} + 31'd1;
         if (n < MIN_FILE_BYTES) begin
            code = ERR_HEADER;
         end else if (walk_err != ERR_NONE) begin
            code = walk_err;
         end else begin
            case (walk_phase)
               PH_XLEN_LO, PH_XLEN_HI: code = ERR_XLEN;
               PH_EXTRA:               code = ERR_EXTRA;
               PH_NAME:                code = ERR_NAME;
               PH_COMMENT:             code = ERR_COMMENT;
               PH_CRC0, PH_CRC1:       code = ERR_CRC;
               PH_BODY: begin
                  code = (n < {1'b0, walk_hdr_len} + 31'(TRAILER_BYTES)) ? ERR_TRUNCATED
                                                                         : ERR_NONE;
               end
               default:                code = ERR_HEADER;
            endcase
         end
         res.finished = 1'b1;
         res.error_code = code;
         res.body_offset = (code == ERR_NONE) ? walk_hdr_len : '0;
         walk_reset();
      end
      return res;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on result beat %0d: %s is %0h, expected %0h",
               beats_checked, field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycles, due_results.size());
         $display("** gzip_header_parser_core: FAILED **");
         $finish;
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (rx_calm) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run != 0) begin
         rsp_stall <= 1'b1;
         stall_run <= stall_run - 1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 3) == 0) stall_run <= pick_gap();
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (due_results.size() == 0) begin
            report_mismatch("beat with nothing due, data", 32'(rsp_data), 32'h0);
         end else begin
            want_rsp = due_results.pop_front();
            if (rsp_data.finished !== want_rsp.finished)
               report_mismatch("finished", 32'(rsp_data.finished), 32'(want_rsp.finished));
            if (rsp_data.error_code !== want_rsp.error_code)
               report_mismatch("error_code", 32'(rsp_data.error_code), 32'(want_rsp.error_code));
            if (rsp_data.body_offset !== want_rsp.body_offset)
               report_mismatch("body_offset", 32'(rsp_data.body_offset),
                               32'(want_rsp.body_offset));
            if (rsp_data.in_header !== want_rsp.in_header)
               report_mismatch("in_header", 32'(rsp_data.in_header), 32'(want_rsp.in_header));
            if (want_rsp.finished) verdict_count[want_rsp.error_code]++;
         end
         beats_checked++;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eof);
      req_type item;
      rsp_type res;
      int      gap;
      item.byte_in = b;
      item.end_of_file = eof;
      gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      res = walk_header_byte(item);
      due_results = {due_results, res};
      bytes_sent++;
   endtask

   // sends len bytes of f, padding with random bytes past its end
   task automatic send_file(input octet_queue_type f, input int len);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         b = (i < f.size()) ? f[i] : 8'($urandom);
         send_byte(b, i == len - 1);
      end
      files_sent++;
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   function automatic octet_queue_type build_member(input logic [7:0] flags, input int xlen,
                                                    input int name_len, input int comment_len,
                                                    input int trailer);
      octet_queue_type f;
      f = {f, ID1_BYTE};
      f = {f, ID2_BYTE};
      f = {f, CM_DEFLATE};
      f = {f, flags};
      repeat (6) f = {f, 8'($urandom)};
      if ((flags & FLG_FEXTRA) != 0) begin
         f = {f, xlen[7:0]};
         f = {f, xlen[15:8]};
         repeat (xlen) f = {f, 8'($urandom)};
      end
      if ((flags & FLG_FNAME) != 0) begin
         repeat (name_len) f = {f, 8'($urandom_range(1, 255))};
         f = {f, 8'h00};
      end
      if ((flags & FLG_FCOMMENT) != 0) begin
         repeat (comment_len) f = {f, 8'($urandom_range(1, 255))};
         f = {f, 8'h00};
      end
      if ((flags & FLG_FHCRC) != 0) repeat (2) f = {f, 8'($urandom)};
      repeat (trailer) f = {f, 8'($urandom)};
      return f;
   endfunction

   task automatic test_short_files();
      octet_queue_type f;
      f = build_member(8'h00, 0, 0, 0, 8);
      send_file(f, 1);
      f[0] = 8'hff;
      send_file(f, 1);
      f[0] = ID1_BYTE;
      send_file(f, 17);
      f[1] = 8'h00;
      send_file(f, 17);
   endtask

   task automatic test_minimal_member();
      octet_queue_type f;
      f = build_member(8'h00, 0, 0, 0, 8);
      for (int i = 4; i < 10; i++) f[i] = 8'hff;
      send_file(f, f.size());
      for (int i = 4; i < 18; i++) f[i] = 8'h00;
      f[3] = 8'h01;
      send_file(f, f.size());
   endtask

   task automatic test_bad_id_and_method();
      octet_queue_type f;
      for (int k = 0; k < 3; k++) begin
         f = build_member(8'h00, 0, 0, 0, 10);
         f[k] = (k == 0) ? 8'h00 : (k == 1) ? 8'h1f : 8'h07;
         send_file(f, f.size());
      end
   endtask

   task automatic test_reserved_flags();
      octet_queue_type f;
      for (int k = 5; k < 8; k++) begin
         f = build_member(8'h00, 0, 0, 0, 10);
         f[3] = 8'h01 << k;
         send_file(f, f.size());
      end
      f = build_member(8'h00, 0, 0, 0, 10);
      f[3] = 8'hff;
      f[0] = 8'h1e;
      send_file(f, f.size());
   endtask

   task automatic test_optional_fields();
      send_file(build_member(FLG_FEXTRA, 0, 0, 0, 8), 20);
      send_file(build_member(FLG_FEXTRA, 1, 0, 0, 8), 21);
      send_file(build_member(FLG_FNAME | FLG_FCOMMENT, 0, 0, 0, 8), 20);
      send_file(build_member(FLG_FHCRC, 0, 0, 0, 8), 20);
      send_file(build_member(8'h1f, 3, 2, 1, 9), 28);
   endtask

   // cut one member inside each section in turn, then send it whole
   task automatic test_truncations();
      octet_queue_type f;
      int              cuts[10] = '{11, 12, 20, 24, 27, 31, 35, 36, 43, 44};
      f = build_member(FLG_FEXTRA | FLG_FNAME | FLG_FCOMMENT | FLG_FHCRC, 12, 4, 4, 8);
      foreach (cuts[i]) send_file(f, cuts[i]);
   endtask

   // extra field whose length needs the high length byte
   task automatic test_long_extra();
      octet_queue_type f;
      tx_calm = 1'b1;
      rx_calm = 1'b1;
      f = build_member(FLG_FEXTRA | FLG_FNAME, 16'h0100, 3, 0, 8);
      send_file(f, f.size());
      wait_all_results();
      tx_calm = 1'b0;
      rx_calm = 1'b0;
   endtask

   task automatic test_back_to_back();
      octet_queue_type f;
      tx_calm = 1'b1;
      for (int k = 0; k < 3; k++) begin
         f = build_member(8'($urandom) & 8'h1f, $urandom_range(0, 4), 1, 1, 8);
         send_file(f, f.size());
      end
      tx_calm = 1'b0;
      wait_all_results();
      f = build_member(FLG_FNAME, 0, 5, 0, 8);
      send_file(f, f.size());
   endtask

   task automatic test_random_files();
      octet_queue_type f;
      logic [7:0]      flags;
      int              start;
      int              kind;
      int              len;
      int              xlen;
      int              pos;
      start = bytes_sent;
      while (bytes_sent < start + RANDOM_BYTES) begin
         tx_calm = ($urandom_range(0, 7) == 0);
         rx_calm = ($urandom_range(0, 7) == 0);
         kind = $urandom_range(0, 99);
         flags = 8'($urandom) & 8'h1f;
         xlen = $urandom_range(0, 99);
         xlen = (xlen < 70) ? $urandom_range(0, 6) :
                (xlen < 95) ? $urandom_range(0, 40) : $urandom_range(256, 300);
         f = build_member(flags, xlen, $urandom_range(0, 8), $urandom_range(0, 8),
                          $urandom_range(0, 16));
         len = f.size();
         if (kind < 10) begin
            f = {};
            len = $urandom_range(1, 40);
         end else if (kind < 20) begin
            pos = $urandom_range(0, 3);
            if (pos == 3) f[3] = f[3] | (8'h20 << $urandom_range(0, 2));
            else f[pos] = f[pos] ^ 8'($urandom_range(1, 255));
         end else if (kind < 45) begin
            len = $urandom_range(1, f.size());
         end
         send_file(f, len);
         if ($urandom_range(0, 19) == 0) wait_all_results();
      end
      tx_calm = 1'b0;
      rx_calm = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_short_files();
      test_minimal_member();
      test_bad_id_and_method();
      test_reserved_flags();
      test_optional_fields();
      test_truncations();
      test_back_to_back();
      test_long_extra();
      test_random_files();
      req_valid <= 1'b0;
      wait_all_results();
      repeat (4) @(posedge clock);
      $display("%0d files, %0d bytes sent, %0d result beats checked",
               files_sent, bytes_sent, beats_checked);
      $display("verdicts per code 0..8: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
               verdict_count[0], verdict_count[1], verdict_count[2], verdict_count[3],
               verdict_count[4], verdict_count[5], verdict_count[6], verdict_count[7],
               verdict_count[8]);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("** gzip_header_parser_core: PASSED **");
      end else begin
         $display("** gzip_header_parser_core: FAILED **");
      end
      $finish;
   end

endmodule
